// ===== src/ffca_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ffca_pkg;

	localparam int FREE_SLOTS = 64;
	localparam int IDX_W      = $clog2(FREE_SLOTS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int CFG_IDX_W  = 8;

	localparam logic [31:0] CHUNK_BYTES       = 32'd65536;
	// must stay a multiple of ALIGN_BYTES: rounding and header add fold into one add
	localparam logic [31:0] HEADER_BYTES      = 32'd16;
	localparam logic [31:0] ALIGN_BYTES       = 32'd8;
	localparam logic [31:0] SPLIT_MIN         = HEADER_BYTES + ALIGN_BYTES;
	localparam logic [31:0] RESET_HEAP_START  = 32'd65536;
	localparam logic [31:0] RESET_HEAP_END    = 32'd16777216;

	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_START = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_END   = 8'd1;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [2:0] {
		ST_OK   = 3'd0,
		ST_OOM  = 3'd1,
		ST_ZERO = 3'd2,
		ST_FULL = 3'd3,
		ST_NULL = 3'd4
	} status_t;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,
		OP_RD_IDX,
		OP_INC,
		OP_TAKE,
		OP_RD_UP,
		OP_SD_WR,
		OP_DEC,
		OP_SPLIT,
		OP_GROW,
		OP_BUMP_GRANT,
		OP_SET_FULL,
		OP_PF_FREE,
		OP_PREV,
		OP_NEXT,
		OP_MNEXT,
		OP_WR_PREV,
		OP_WR_NEXT,
		OP_SU_INIT,
		OP_RD_SU,
		OP_SU_WR,
		OP_INSERT,
		OP_FIN_GRANT,
		OP_FIN_OK,
		OP_FIN_OOM,
		OP_FIN_ZERO,
		OP_FIN_FULL,
		OP_FIN_NULL
	} dp_op_t;

	typedef struct packed {
		logic cmd_free;
		logic req_zero;
		logic too_big;
		logic addr_null;
		logic idx_lt;
		logic fit;
		logic r_lt;
		logic split_ok;
		logic need_grow;
		logic grow_fail;
		logic bank;
		logic mprev;
		logic mnext;
		logic full;
		logic sd_more;
		logic su_more;
	} dp_stat_t;

endpackage
`default_nettype wire

// ===== src/ffca_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ffca_dp (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire ffca_pkg::dp_op_t                   op,
	output ffca_pkg::dp_stat_t                      stat,
	input  wire logic                               cfg_we,
	input  wire logic [ffca_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [31:0]                        cfg_data,
	input  wire logic                               cmd,
	input  wire logic [31:0]                        request_size,
	input  wire logic [31:0]                        free_addr,
	input  wire logic [31:0]                        free_block_size,
	output logic [31:0]                             grant_addr,
	output logic [31:0]                             grant_block_size,
	output logic [2:0]                              status,
	output logic                                    done
);

	localparam int IW = ffca_pkg::IDX_W;
	localparam int CW = ffca_pkg::CNT_W;

	logic [63:0] mem [ffca_pkg::FREE_SLOTS];
	logic [63:0] rdata_q;

	logic        cmd_q;
	logic [31:0] req_q, faddr_q, fsize_q;
	logic [32:0] total_q;
	logic [31:0] op_start_q, op_size_q, merged_q;
	logic [31:0] prev_start_q, prev_size_q, next_start_q, next_size_q;
	logic [31:0] bstart_q, bsize_q;
	logic [31:0] bump_q, cend_q, brk_q, he_q;
	logic [CW-1:0] idx_q, cnt_q, sp_q;
	logic        mnext_q;
	ffca_pkg::status_t st_q;

	logic [31:0] r_start, r_size;
	logic [32:0] total_c, want_c;
	logic [33:0] split_need_c;
	logic [31:0] tail_c;
	logic [32:0] ns_sum_c, nsz_sum_c, ps_sum_c, pm_sum_c;
	logic        mnext_c;
	logic [CW-1:0] idx_inc_c, idx_dec_c, sp_dec_c;
	logic        rd_en, wr_en;
	logic [CW-1:0] rd_addr, wr_addr;
	logic [63:0] wr_data;

	assign r_start = rdata_q[63:32];
	assign r_size  = rdata_q[31:0];

	assign idx_inc_c = idx_q + CW'(1);
	assign idx_dec_c = idx_q - CW'(1);
	assign sp_dec_c  = sp_q - CW'(1);

	// round up to the alignment and add the header in one add
	assign total_c = ({1'b0, request_size}
		+ 33'(ffca_pkg::ALIGN_BYTES - 32'd1 + ffca_pkg::HEADER_BYTES))
		& ~33'(ffca_pkg::ALIGN_BYTES - 32'd1);
	assign split_need_c = {1'b0, total_q} + 34'(ffca_pkg::SPLIT_MIN);
	assign want_c = (total_q > {1'b0, ffca_pkg::CHUNK_BYTES}) ? total_q
		: {1'b0, ffca_pkg::CHUNK_BYTES};
	assign tail_c = (cend_q >= bump_q) ? (cend_q - bump_q) : 32'd0;

	assign ns_sum_c  = {1'b0, op_start_q} + {1'b0, op_size_q};
	assign nsz_sum_c = {1'b0, op_size_q} + {1'b0, next_size_q};
	assign mnext_c   = (idx_q < cnt_q) && (ns_sum_c == {1'b0, next_start_q}) && !nsz_sum_c[32];
	assign ps_sum_c  = {1'b0, prev_start_q} + {1'b0, prev_size_q};
	assign pm_sum_c  = {1'b0, prev_size_q} + {1'b0, merged_q};

	always_comb begin
		stat.cmd_free  = (cmd_q == ffca_pkg::CMD_FREE);
		stat.req_zero  = (req_q == 32'd0);
		stat.too_big   = total_q[32];
		stat.addr_null = (faddr_q == 32'd0);
		stat.idx_lt    = (idx_q < cnt_q);
		stat.fit       = ({1'b0, r_size} >= total_q);
		stat.r_lt      = (r_start < op_start_q);
		stat.split_ok  = ({2'b0, bsize_q} >= split_need_c);
		stat.need_grow = (({2'b0, bump_q} + {1'b0, total_q}) > {2'b0, cend_q});
		stat.grow_fail = (({2'b0, brk_q} + {1'b0, want_c}) > {2'b0, he_q});
		stat.bank      = (op_size_q >= ffca_pkg::SPLIT_MIN);
		stat.mprev     = (idx_q != '0) && (ps_sum_c == {1'b0, op_start_q}) && !pm_sum_c[32];
		stat.mnext     = mnext_q;
		stat.full      = (cnt_q == CW'(ffca_pkg::FREE_SLOTS));
		stat.sd_more   = (idx_inc_c < cnt_q);
		stat.su_more   = (sp_q > idx_q);
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q;
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = rdata_q;
		case (op)
			ffca_pkg::OP_RD_IDX: begin
				rd_en = 1'b1;
			end
			ffca_pkg::OP_RD_UP: begin
				rd_en   = 1'b1;
				rd_addr = idx_inc_c;
			end
			ffca_pkg::OP_RD_SU: begin
				rd_en   = 1'b1;
				rd_addr = sp_dec_c;
			end
			ffca_pkg::OP_SD_WR: begin
				wr_en = 1'b1;
			end
			ffca_pkg::OP_SU_WR: begin
				wr_en   = 1'b1;
				wr_addr = sp_q;
			end
			ffca_pkg::OP_WR_PREV: begin
				wr_en   = 1'b1;
				wr_addr = idx_dec_c;
				wr_data = {prev_start_q, prev_size_q + merged_q};
			end
			ffca_pkg::OP_WR_NEXT: begin
				wr_en   = 1'b1;
				wr_data = {op_start_q, merged_q};
			end
			ffca_pkg::OP_INSERT: begin
				wr_en   = 1'b1;
				wr_data = {op_start_q, op_size_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr[IW-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr[IW-1:0]];
		end
	end

	// operand and scan registers
	always_ff @(posedge clk) begin
		case (op)
			ffca_pkg::OP_LOAD: begin
				cmd_q   <= cmd;
				req_q   <= request_size;
				faddr_q <= free_addr;
				fsize_q <= free_block_size;
				total_q <= total_c;
			end
			ffca_pkg::OP_TAKE: begin
				bstart_q <= r_start;
				bsize_q  <= r_size;
			end
			ffca_pkg::OP_SPLIT: begin
				op_start_q <= bstart_q + total_q[31:0];
				op_size_q  <= bsize_q - total_q[31:0];
				bsize_q    <= total_q[31:0];
			end
			ffca_pkg::OP_GROW: begin
				op_start_q <= bump_q;
				op_size_q  <= tail_c;
			end
			ffca_pkg::OP_BUMP_GRANT: begin
				bstart_q <= bump_q;
				bsize_q  <= total_q[31:0];
			end
			ffca_pkg::OP_PF_FREE: begin
				op_start_q <= faddr_q - ffca_pkg::HEADER_BYTES;
				op_size_q  <= fsize_q;
			end
			ffca_pkg::OP_PREV: begin
				prev_start_q <= r_start;
				prev_size_q  <= r_size;
			end
			ffca_pkg::OP_NEXT: begin
				next_start_q <= r_start;
				next_size_q  <= r_size;
			end
			ffca_pkg::OP_MNEXT: begin
				mnext_q  <= mnext_c;
				merged_q <= mnext_c ? nsz_sum_c[31:0] : op_size_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			sp_q   <= '0;
			cnt_q  <= '0;
			bump_q <= 32'd0;
			cend_q <= 32'd0;
			brk_q  <= ffca_pkg::RESET_HEAP_START;
			he_q   <= ffca_pkg::RESET_HEAP_END;
			st_q   <= ffca_pkg::ST_OK;
			done   <= 1'b0;
			grant_addr       <= 32'd0;
			grant_block_size <= 32'd0;
			status           <= ffca_pkg::ST_OK;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == ffca_pkg::CFG_HEAP_START) begin
					brk_q <= cfg_data;
				end else if (cfg_index == ffca_pkg::CFG_HEAP_END) begin
					he_q <= cfg_data;
				end
			end
			case (op)
				ffca_pkg::OP_LOAD: begin
					idx_q <= '0;
					st_q  <= ffca_pkg::ST_OK;
				end
				ffca_pkg::OP_INC, ffca_pkg::OP_PREV, ffca_pkg::OP_SD_WR: begin
					idx_q <= idx_inc_c;
				end
				ffca_pkg::OP_DEC: begin
					cnt_q <= cnt_q - CW'(1);
				end
				ffca_pkg::OP_SPLIT, ffca_pkg::OP_PF_FREE: begin
					idx_q <= '0;
				end
				ffca_pkg::OP_GROW: begin
					idx_q  <= '0;
					brk_q  <= brk_q + want_c[31:0];
					bump_q <= brk_q;
					cend_q <= brk_q + want_c[31:0];
				end
				ffca_pkg::OP_BUMP_GRANT: begin
					bump_q <= bump_q + total_q[31:0];
				end
				ffca_pkg::OP_SET_FULL: begin
					st_q <= ffca_pkg::ST_FULL;
				end
				ffca_pkg::OP_SU_INIT: begin
					sp_q <= cnt_q;
				end
				ffca_pkg::OP_SU_WR: begin
					sp_q <= sp_dec_c;
				end
				ffca_pkg::OP_INSERT: begin
					cnt_q <= cnt_q + CW'(1);
				end
				ffca_pkg::OP_FIN_GRANT: begin
					done             <= 1'b1;
					grant_addr       <= bstart_q + ffca_pkg::HEADER_BYTES;
					grant_block_size <= bsize_q;
					status           <= st_q;
				end
				ffca_pkg::OP_FIN_OK, ffca_pkg::OP_FIN_OOM, ffca_pkg::OP_FIN_ZERO,
				ffca_pkg::OP_FIN_FULL, ffca_pkg::OP_FIN_NULL: begin
					done             <= 1'b1;
					grant_addr       <= 32'd0;
					grant_block_size <= 32'd0;
					case (op)
						ffca_pkg::OP_FIN_OOM:  status <= ffca_pkg::ST_OOM;
						ffca_pkg::OP_FIN_ZERO: status <= ffca_pkg::ST_ZERO;
						ffca_pkg::OP_FIN_FULL: status <= ffca_pkg::ST_FULL;
						ffca_pkg::OP_FIN_NULL: status <= ffca_pkg::ST_NULL;
						default:               status <= ffca_pkg::ST_OK;
					endcase
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== src/ffca_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ffca_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire ffca_pkg::dp_stat_t stat,
	output ffca_pkg::dp_op_t        op
);

	typedef enum logic [4:0] {
		S_IDLE, S_DISP, S_A_RD, S_A_CMP, S_SD_RD, S_SD_WR, S_SPLIT, S_BUMP, S_GCHK,
		S_BUMPG, S_FING, S_P_RD, S_P_CMP, S_P_DEC1, S_P_DEC2, S_SU_RD, S_SU_WR,
		S_PF_OK, S_PF_DROP
	} state_t;

	typedef enum logic [1:0] {
		RET_FREE, RET_SPLIT, RET_BANK
	} ret_t;

	state_t state_q, state_d;
	ret_t   ret_q, ret_d;
	logic   sd_take_q, sd_take_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d   = state_q;
		ret_d     = ret_q;
		sd_take_d = sd_take_q;
		op        = ffca_pkg::OP_NOP;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					op      = ffca_pkg::OP_LOAD;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if (stat.cmd_free) begin
					if (stat.addr_null) begin
						op      = ffca_pkg::OP_FIN_NULL;
						state_d = S_IDLE;
					end else begin
						op      = ffca_pkg::OP_PF_FREE;
						ret_d   = RET_FREE;
						state_d = S_P_RD;
					end
				end else if (stat.req_zero) begin
					op      = ffca_pkg::OP_FIN_ZERO;
					state_d = S_IDLE;
				end else if (stat.too_big) begin
					op      = ffca_pkg::OP_FIN_OOM;
					state_d = S_IDLE;
				end else begin
					state_d = S_A_RD;
				end
			end
			S_A_RD: begin
				if (stat.idx_lt) begin
					op      = ffca_pkg::OP_RD_IDX;
					state_d = S_A_CMP;
				end else begin
					state_d = S_BUMP;
				end
			end
			S_A_CMP: begin
				if (stat.fit) begin
					op        = ffca_pkg::OP_TAKE;
					sd_take_d = 1'b1;
					state_d   = S_SD_RD;
				end else begin
					op      = ffca_pkg::OP_INC;
					state_d = S_A_RD;
				end
			end
			// close the gap: move each later entry down one slot
			S_SD_RD: begin
				if (stat.sd_more) begin
					op      = ffca_pkg::OP_RD_UP;
					state_d = S_SD_WR;
				end else begin
					op      = ffca_pkg::OP_DEC;
					state_d = sd_take_q ? S_SPLIT : S_PF_OK;
				end
			end
			S_SD_WR: begin
				op      = ffca_pkg::OP_SD_WR;
				state_d = S_SD_RD;
			end
			S_SPLIT: begin
				if (stat.split_ok) begin
					op      = ffca_pkg::OP_SPLIT;
					ret_d   = RET_SPLIT;
					state_d = S_P_RD;
				end else begin
					op      = ffca_pkg::OP_FIN_GRANT;
					state_d = S_IDLE;
				end
			end
			S_BUMP: begin
				if (!stat.need_grow) begin
					state_d = S_BUMPG;
				end else if (stat.grow_fail) begin
					op      = ffca_pkg::OP_FIN_OOM;
					state_d = S_IDLE;
				end else begin
					op      = ffca_pkg::OP_GROW;
					state_d = S_GCHK;
				end
			end
			S_GCHK: begin
				if (stat.bank) begin
					ret_d   = RET_BANK;
					state_d = S_P_RD;
				end else begin
					state_d = S_BUMPG;
				end
			end
			S_BUMPG: begin
				op      = ffca_pkg::OP_BUMP_GRANT;
				state_d = S_FING;
			end
			S_FING: begin
				op      = ffca_pkg::OP_FIN_GRANT;
				state_d = S_IDLE;
			end
			S_P_RD: begin
				if (stat.idx_lt) begin
					op      = ffca_pkg::OP_RD_IDX;
					state_d = S_P_CMP;
				end else begin
					state_d = S_P_DEC1;
				end
			end
			S_P_CMP: begin
				if (stat.r_lt) begin
					op      = ffca_pkg::OP_PREV;
					state_d = S_P_RD;
				end else begin
					op      = ffca_pkg::OP_NEXT;
					state_d = S_P_DEC1;
				end
			end
			S_P_DEC1: begin
				op      = ffca_pkg::OP_MNEXT;
				state_d = S_P_DEC2;
			end
			S_P_DEC2: begin
				if (stat.mprev && stat.mnext) begin
					op        = ffca_pkg::OP_WR_PREV;
					sd_take_d = 1'b0;
					state_d   = S_SD_RD;
				end else if (stat.mprev) begin
					op      = ffca_pkg::OP_WR_PREV;
					state_d = S_PF_OK;
				end else if (stat.mnext) begin
					op      = ffca_pkg::OP_WR_NEXT;
					state_d = S_PF_OK;
				end else if (stat.full) begin
					state_d = S_PF_DROP;
				end else begin
					op      = ffca_pkg::OP_SU_INIT;
					state_d = S_SU_RD;
				end
			end
			// open a slot: move entries up one, top first
			S_SU_RD: begin
				if (stat.su_more) begin
					op      = ffca_pkg::OP_RD_SU;
					state_d = S_SU_WR;
				end else begin
					op      = ffca_pkg::OP_INSERT;
					state_d = S_PF_OK;
				end
			end
			S_SU_WR: begin
				op      = ffca_pkg::OP_SU_WR;
				state_d = S_SU_RD;
			end
			S_PF_OK: begin
				case (ret_q)
					RET_FREE: begin
						op      = ffca_pkg::OP_FIN_OK;
						state_d = S_IDLE;
					end
					RET_SPLIT: begin
						op      = ffca_pkg::OP_FIN_GRANT;
						state_d = S_IDLE;
					end
					default: begin
						state_d = S_BUMPG;
					end
				endcase
			end
			S_PF_DROP: begin
				case (ret_q)
					RET_FREE: begin
						op      = ffca_pkg::OP_FIN_FULL;
						state_d = S_IDLE;
					end
					RET_SPLIT: begin
						op      = ffca_pkg::OP_FIN_GRANT;
						state_d = S_IDLE;
					end
					default: begin
						op      = ffca_pkg::OP_SET_FULL;
						state_d = S_BUMPG;
					end
				endcase
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ret_q     <= RET_FREE;
			sd_take_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			ret_q     <= ret_d;
			sd_take_q <= sd_take_d;
		end
	end

endmodule
`default_nettype wire

// ===== src/first_fit_coalescing_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// First-fit heap allocator with an address-ordered, coalescing free table.
// Command channel: an item is taken when start is high and busy is low; cmd
// selects allocate (request_size) or free (free_addr, free_block_size).
// Each item gives one result word on grant_addr, grant_block_size and status,
// shown for exactly one cycle while done is high; the receiver cannot stall.
// busy stays high from acceptance until the result is shown and is low while
// done is high, so the next item can be taken in the same cycle as done.
// The state machine walks the free table through a single-port memory,
// one entry access at a time:
//   early exits (zero size, null free, oversize): no table access
//   allocate: first-fit scan, then shift down and a put-free pass, or a bump grant
//   free: position search, merge, or entries moved up to open a slot
// The free table holds up to 64 entries.
// Configuration: cfg_valid/cfg_ready write channel, index 0 heap_start (also
// loads the break), index 1 heap_end; cfg_ready is high only while idle.
// Reset clears the free count, bump and chunk pointers and loads the default
// heap bounds; the free table memory is not cleared.
module first_fit_coalescing_allocator (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic                           cmd,
	input  wire logic [31:0]                    request_size,
	input  wire logic [31:0]                    free_addr,
	input  wire logic [31:0]                    free_block_size,
	output logic [31:0]                         grant_addr,
	output logic [31:0]                         grant_block_size,
	output logic [2:0]                          status,
	output logic                                done,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [ffca_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                    cfg_data
);

	ffca_pkg::dp_op_t   op;
	ffca_pkg::dp_stat_t stat;

	assign cfg_ready = !busy;

	ffca_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.op     (op)
	);

	ffca_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.op               (op),
		.stat             (stat),
		.cfg_we           (cfg_valid && cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.cmd              (cmd),
		.request_size     (request_size),
		.free_addr        (free_addr),
		.free_block_size  (free_block_size),
		.grant_addr       (grant_addr),
		.grant_block_size (grant_block_size),
		.status           (status),
		.done             (done)
	);

endmodule
`default_nettype wire

// ===== src/ffca_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ffca_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [31:0] grant_addr,
	input wire logic [31:0] grant_block_size,
	input wire logic [2:0]  status
);

	// a result only ends a command that was in flight
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without a command in flight");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted word did not raise busy");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ffca_pkg::ST_OK || status == ffca_pkg::ST_OOM ||
		status == ffca_pkg::ST_ZERO || status == ffca_pkg::ST_FULL ||
		status == ffca_pkg::ST_NULL)) else $error("status code out of range");

	a_fail_null: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ffca_pkg::ST_OOM || status == ffca_pkg::ST_ZERO ||
		status == ffca_pkg::ST_NULL))
		|-> (grant_addr == 32'd0 && grant_block_size == 32'd0))
		else $error("failed request carries a grant");

	a_min_block: assert property (@(posedge clk) disable iff (!arst_n)
		(done && grant_block_size != 32'd0) |-> (grant_block_size >= ffca_pkg::SPLIT_MIN))
		else $error("granted block smaller than header plus alignment");

endmodule

bind first_fit_coalescing_allocator ffca_checker u_ffca_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.done             (done),
	.grant_addr       (grant_addr),
	.grant_block_size (grant_block_size),
	.status           (status)
);
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

	typedef struct {
		logic [31:0] addr;
		logic [31:0] size;
		ffca_pkg::status_t st;
	} grant_word_t;

	typedef struct {
		logic [31:0] addr;
		logic [31:0] size;
	} live_blk_t;

	class heap_scoreboard;
		logic [31:0] blk_start[ffca_pkg::FREE_SLOTS];
		logic [31:0] blk_size[ffca_pkg::FREE_SLOTS];
		int unsigned n_free;
		logic [31:0] bump, chunk_top, brk, lo_bound, hi_bound;
		grant_word_t want_q[$];
		int errors;
		int checked;

		function void init();
			lo_bound  = ffca_pkg::RESET_HEAP_START;
			hi_bound  = ffca_pkg::RESET_HEAP_END;
			n_free    = 0;
			bump      = 0;
			chunk_top = 0;
			brk       = lo_bound;
			errors    = 0;
			checked   = 0;
		endfunction

		function void write_reg(logic [ffca_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
			if (idx == ffca_pkg::CFG_HEAP_START) begin
				lo_bound = val;
				brk = val;
			end else if (idx == ffca_pkg::CFG_HEAP_END) begin
				hi_bound = val;
			end
		endfunction

		function void drop_entry(int unsigned idx);
			int unsigned i;
			for (i = idx; i + 1 < n_free; i++) begin
				blk_start[i] = blk_start[i+1];
				blk_size[i]  = blk_size[i+1];
			end
			n_free--;
		endfunction

		// insert in address order, coalesce with neighbors; 0 when dropped
		function bit bank_block(logic [31:0] s, logic [31:0] sz);
			int unsigned pos;
			int unsigned i;
			bit mnext, mprev;
			logic [63:0] merged;
			pos = 0;
			mnext = 0;
			mprev = 0;
			merged = {32'b0, sz};
			while (pos < n_free && blk_start[pos] < s)
				pos++;
			if (pos < n_free && {32'b0, s} + sz == {32'b0, blk_start[pos]} &&
			    {32'b0, sz} + blk_size[pos] <= 64'hFFFF_FFFF) begin
				mnext = 1;
				merged += blk_size[pos];
			end
			if (pos > 0 && {32'b0, blk_start[pos-1]} + blk_size[pos-1] == {32'b0, s} &&
			    {32'b0, blk_size[pos-1]} + merged <= 64'hFFFF_FFFF)
				mprev = 1;
			if (mprev && mnext) begin
				blk_size[pos-1] = blk_size[pos-1] + merged[31:0];
				drop_entry(pos);
			end else if (mprev) begin
				blk_size[pos-1] = blk_size[pos-1] + merged[31:0];
			end else if (mnext) begin
				blk_start[pos] = s;
				blk_size[pos]  = merged[31:0];
			end else begin
				if (n_free >= ffca_pkg::FREE_SLOTS)
					return 0;
				for (i = n_free; i > pos; i--) begin
					blk_start[i] = blk_start[i-1];
					blk_size[i]  = blk_size[i-1];
				end
				blk_start[pos] = s;
				blk_size[pos]  = sz;
				n_free++;
			end
			return 1;
		endfunction

		function grant_word_t note(logic c, logic [31:0] req, logic [31:0] fa,
		                           logic [31:0] fs);
			grant_word_t r;
			logic [63:0] total, want;
			logic [31:0] bs, bsz, tail, old_brk;
			int unsigned i;
			bit fin, ok;
			r.addr = 0;
			r.size = 0;
			r.st   = ffca_pkg::ST_OK;
			if (c == ffca_pkg::CMD_FREE) begin
				if (fa == 0)
					r.st = ffca_pkg::ST_NULL;
				else if (!bank_block(fa - ffca_pkg::HEADER_BYTES, fs))
					r.st = ffca_pkg::ST_FULL;
			end else if (req == 0) begin
				r.st = ffca_pkg::ST_ZERO;
			end else begin
				total = (({32'b0, req} + 64'd7) & ~64'd7) + ffca_pkg::HEADER_BYTES;
				fin = 0;
				if (total > 64'hFFFF_FFFF) begin
					r.st = ffca_pkg::ST_OOM;
					fin = 1;
				end
				for (i = 0; !fin && i < n_free; i++) begin
					if ({32'b0, blk_size[i]} >= total) begin
						bs  = blk_start[i];
						bsz = blk_size[i];
						drop_entry(i);
						if ({32'b0, bsz} >= total + ffca_pkg::SPLIT_MIN) begin
							void'(bank_block(bs + total[31:0], bsz - total[31:0]));
							bsz = total[31:0];
						end
						r.addr = bs + ffca_pkg::HEADER_BYTES;
						r.size = bsz;
						fin = 1;
					end
				end
				if (!fin) begin
					ok = 1;
					if ({32'b0, bump} + total > {32'b0, chunk_top}) begin
						want = total > ffca_pkg::CHUNK_BYTES ? total
							: {32'b0, ffca_pkg::CHUNK_BYTES};
						old_brk = brk;
						if ({32'b0, old_brk} + want > {32'b0, hi_bound}) begin
							r.st = ffca_pkg::ST_OOM;
							ok = 0;
						end else begin
							tail = chunk_top >= bump ? chunk_top - bump : 32'd0;
							brk = old_brk + want[31:0];
							if (tail >= ffca_pkg::SPLIT_MIN && !bank_block(bump, tail))
								r.st = ffca_pkg::ST_FULL;
							bump = old_brk;
							chunk_top = old_brk + want[31:0];
						end
					end
					if (ok) begin
						r.addr = bump + ffca_pkg::HEADER_BYTES;
						r.size = total[31:0];
						bump = bump + total[31:0];
					end
				end
			end
			want_q.push_back(r);
			return r;
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] exp);
			$display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, exp);
			errors++;
		endtask

		task check(logic [31:0] ga, logic [31:0] gs, logic [2:0] st);
			grant_word_t e;
			if (want_q.size() == 0) begin
				report("unexpected result", ga, 32'h0);
				return;
			end
			e = want_q.pop_front();
			checked++;
			if (ga !== e.addr) report("grant_addr", ga, e.addr);
			if (gs !== e.size) report("grant_block_size", gs, e.size);
			if (st !== e.st) report("status", {29'b0, st}, {29'b0, e.st});
		endtask

		function int pending();
			return want_q.size();
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic cmd = ffca_pkg::CMD_ALLOC;
	logic [31:0] request_size = 0, free_addr = 0, free_block_size = 0;
	logic cfg_valid = 0;
	logic [ffca_pkg::CFG_IDX_W-1:0] cfg_index = ffca_pkg::CFG_HEAP_START;
	logic [31:0] cfg_data = 0;
	logic busy, done, cfg_ready;
	logic [31:0] grant_addr, grant_block_size;
	logic [2:0] status;

	heap_scoreboard sb;
	live_blk_t live_q[$];
	int accepted = 0;
	int idle_bursts = 1;
	int quiet = 0;
	bit moved;

	localparam int WATCH_LIMIT = 6000;

	first_fit_coalescing_allocator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.request_size(request_size), .free_addr(free_addr),
		.free_block_size(free_block_size), .grant_addr(grant_addr),
		.grant_block_size(grant_block_size), .status(status), .done(done),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check(grant_addr, grant_block_size, status);
	end

	// watchdog: any accepted word on either side, or a result, resets the count
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCH_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", WATCH_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	task send_item(logic c, logic [31:0] req, logic [31:0] fa, logic [31:0] fs);
		grant_word_t r;
		start <= 1;
		cmd <= c;
		request_size <= req;
		free_addr <= fa;
		free_block_size <= fs;
		do @(posedge clk); while (busy);
		r = sb.note(c, req, fa, fs);
		accepted++;
		if (c == ffca_pkg::CMD_ALLOC && r.addr != 0) begin
			live_q.push_back('{addr: r.addr, size: r.size});
		end
		@(negedge clk);
		// hold start high into the next item unless a gap burst comes
		if (idle_bursts && $urandom_range(0, 3) == 0) begin
			start <= 0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
	endtask

	task alloc(logic [31:0] req);
		send_item(ffca_pkg::CMD_ALLOC, req, $urandom, $urandom);
	endtask

	task release_blk(logic [31:0] fa, logic [31:0] fs);
		send_item(ffca_pkg::CMD_FREE, $urandom, fa, fs);
	endtask

	task drain();
		start <= 0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task write_cfg(logic [ffca_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
		drain();
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task random_item();
		int pick, k;
		live_blk_t b;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			case ($urandom_range(0, 9))
				0: alloc($urandom);
				1: alloc($urandom_range(1000, 70000));
				default: alloc($urandom_range(1, 300));
			endcase
		end else if (pick < 85 && live_q.size() != 0) begin
			k = $urandom_range(0, live_q.size() - 1);
			b = live_q[k];
			live_q.delete(k);
			release_blk(b.addr, b.size);
		end else if (pick < 90) begin
			release_blk(0, $urandom);
		end else begin
			release_blk($urandom, $urandom);
		end
	endtask

	initial begin
		logic [31:0] a0, a1, a2;
		sb = new();
		sb.init();
		repeat (4) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: edge sizes, null free, wrap, coalescing, overflow
		alloc(0);
		alloc(32'hFFFF_FFFF);
		alloc(32'hFFFF_FFF8);
		alloc(32'hFFFF_FFE8);
		alloc(1);
		alloc(8);
		alloc(9);
		release_blk(0, 32'hFFFF_FFFF);
		release_blk(32'd4, 32'd8);
		release_blk(32'h0010_0010, 32'h10);
		release_blk(32'h0010_0020, 32'hFFFF_FFF8);
		release_blk(32'h0020_0010, 32'h40);
		release_blk(32'h0020_0010, 32'h20);
		drain();
		a0 = sb.bump + ffca_pkg::HEADER_BYTES;
		alloc(40);
		a1 = sb.bump + ffca_pkg::HEADER_BYTES;
		alloc(40);
		a2 = sb.bump + ffca_pkg::HEADER_BYTES;
		alloc(40);
		release_blk(a0, 56);
		release_blk(a2, 56);
		release_blk(a1, 56);
		alloc(24);
		release_blk(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		alloc(100);

		// fill the table, then force a grow that cannot bank the old tail
		write_cfg(ffca_pkg::CFG_HEAP_START, 32'h0100_0000);
		write_cfg(ffca_pkg::CFG_HEAP_END, 32'h0400_0000);
		write_cfg(8'd2, 32'hDEAD_BEEF);
		idle_bursts = 0;
		for (int k = 0; k < 66; k++)
			release_blk(32'h0300_0010 + k * 64, 32'd32);
		alloc(70000);
		alloc(16);
		idle_bursts = 1;

		// random phases over several heap windows
		for (int ph = 0; ph < 6; ph++) begin
			live_q.delete();
			case (ph)
				0: begin
					write_cfg(ffca_pkg::CFG_HEAP_START, ffca_pkg::RESET_HEAP_START);
					write_cfg(ffca_pkg::CFG_HEAP_END, ffca_pkg::RESET_HEAP_END);
				end
				1: begin
					write_cfg(ffca_pkg::CFG_HEAP_START, 32'h0);
					write_cfg(ffca_pkg::CFG_HEAP_END, 32'hFFFF_FFFF);
				end
				2: begin
					write_cfg(ffca_pkg::CFG_HEAP_START, 32'h0000_1000);
					write_cfg(ffca_pkg::CFG_HEAP_END, 32'h0004_0000);
				end
				3: begin
					write_cfg(ffca_pkg::CFG_HEAP_START, 32'hFFFF_FFFF);
					write_cfg(ffca_pkg::CFG_HEAP_END, 32'h0);
				end
				4: begin
					write_cfg(ffca_pkg::CFG_HEAP_START, 32'hFFF0_0000);
					write_cfg(ffca_pkg::CFG_HEAP_END, 32'hFFFF_FFFF);
				end
				default: begin
					write_cfg(ffca_pkg::CFG_HEAP_START, 32'h0200_0000);
					write_cfg(ffca_pkg::CFG_HEAP_END, 32'h0300_0000);
				end
			endcase
			for (int n = 0; n < 77; n++) begin
				if (ph == 5 && n >= 40)
					idle_bursts = 0;
				random_item();
			end
		end

		start <= 0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		$display("covered %0d commands and %0d results over 8 heap windows,", accepted,
		         sb.checked);
		$display("including table overflow, tail loss, merges and out-of-memory paths");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
